// File: rtl/core/sd_command_line_engine_core_macros.svh
// ----------------------------------------------------------------------------
// SD command line engine - assertion macros
// Shared concurrent assertion shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef SD_COMMAND_LINE_ENGINE_CORE_MACROS_SVH
`define SD_COMMAND_LINE_ENGINE_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SDCLE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SDCLE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sdcle_pkg.sv
// ----------------------------------------------------------------------------
// SD command line engine - package
// Widths, codes and the CRC7 helper shared by the core and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sdcle_pkg;

  // response length limit and the counter that holds it
  localparam int MAX_RESPONSE_BYTES = 17;
  localparam int RESP_W = $clog2(MAX_RESPONSE_BYTES + 1);

  // stream widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  // command kind on in_tuser
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // status codes
  localparam logic [1:0] STAT_IDLE    = 2'd0;
  localparam logic [1:0] STAT_BUSY    = 2'd1;
  localparam logic [1:0] STAT_OK      = 2'd2;
  localparam logic [1:0] STAT_TIMEOUT = 2'd3;

  // frame geometry
  localparam int HEAD_BITS  = 40;
  localparam int FRAME_BITS = 48;
  localparam logic [1:0] FRAME_PREFIX = 2'b01;   // start bit, transmission bit
  localparam logic [15:0] TIMEOUT_RESET = 16'd1024;

  // CRC7 generator x^7 + x^3 + 1
  localparam logic [6:0] CRC7_POLY = 7'h09;

  typedef logic [HEAD_BITS-1:0][6:0] crc_cols_t;

  // CRC of a single set bit at each head position (CRC is linear, init 0)
  function automatic crc_cols_t crc7_cols_build();
    crc_cols_t  cols;
    logic [6:0] crc;
    logic       fb;
    for (int pos = 0; pos < HEAD_BITS; pos++) begin
      crc = '0;
      for (int i = HEAD_BITS - 1; i >= 0; i--) begin
        fb  = crc[6] ^ (i == pos);
        crc = {crc[5:0], 1'b0};
        if (fb) crc = crc ^ CRC7_POLY;
      end
      cols[pos] = crc;
    end
    return cols;
  endfunction

  localparam crc_cols_t CRC7_COLS = crc7_cols_build();

  // CRC7 of the 40-bit head as an XOR of per-bit columns
  function automatic logic [6:0] crc7_of(logic [HEAD_BITS-1:0] head);
    logic [6:0] crc;
    crc = '0;
    for (int i = 0; i < HEAD_BITS; i++) begin
      if (head[i]) crc = crc ^ CRC7_COLS[i];
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/sd_command_line_engine_core.sv
// ----------------------------------------------------------------------------
// SD command line engine
// Sends a CRC7-protected 48-bit command on the SD CMD line, waits for the
// response start bit, captures response bytes and adds optional trailer clocks.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents
// in_*    | slave     | tuser: command kind; tdata: index, argument, length,
//         |           | trailer, sampled CMD level (one line clock per tick)
// out_*   | master    | tuser: byte valid; tlast: last byte; tdata: line
//         |           | level, drive enable, response byte, status
// cfg_*   | write     | start-bit timeout in line samples
//
// One transfer in gives one transfer out; a new item is taken every cycle while
// the output register is empty or being drained. Each item is handled in the cycle it is
// accepted and the result lands in the output register, shown in the next cycle.
// in_tready is high while the output register is empty or being drained.
// rst_n is synchronous, active low; it clears all but the output payload, timeout is 1024.
// ----------------------------------------------------------------------------
`default_nettype none

module sd_command_line_engine_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration
  input  wire logic                             cfg_wr_en,
  input  wire logic [15:0]                      cfg_wr_data,
  // input stream
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [5:0] cmd_index, [37:6] argument, [42:38] response_bytes, [43] trailer,
  // [44] cmd_line_in, [47:45] zero
  input  wire logic [sdcle_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] command
  input  wire logic                             in_tuser,
  // result stream
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [0] cmd_line_out, [1] driving, [9:2] response_byte, [11:10] status,
  // [15:12] zero
  output logic [sdcle_pkg::OUT_DATA_W-1:0]      out_tdata,
  // [0] byte_valid
  output logic                                  out_tuser,
  // last_byte
  output logic                                  out_tlast
);

  import sdcle_pkg::*;

  // phase codes
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_SEND    = 3'd1;
  localparam logic [2:0] PH_WAIT    = 3'd2;
  localparam logic [2:0] PH_RECV    = 3'd3;
  localparam logic [2:0] PH_TRAIL   = 3'd4;
  localparam logic [2:0] PH_OK      = 3'd5;
  localparam logic [2:0] PH_TIMEOUT = 3'd6;

  localparam logic [5:0] FRAME_LEN = 6'(FRAME_BITS);
  localparam logic [5:0] BYTE_LEN  = 6'd8;

  // input field views
  logic [5:0]  in_index;
  logic [31:0] in_arg;
  logic [4:0]  in_resp;
  logic        in_trailer;
  logic        in_sample;

  assign in_index   = in_tdata[5:0];
  assign in_arg     = in_tdata[37:6];
  assign in_resp    = in_tdata[42:38];
  assign in_trailer = in_tdata[43];
  assign in_sample  = in_tdata[44];

  // state
  logic [15:0]           timeout_r;
  logic [2:0]            phase_r,   phase_nxt;
  logic [47:0]           frame_r,   frame_nxt;
  logic [5:0]            bits_r,    bits_nxt;
  logic [15:0]           wait_r,    wait_nxt;
  logic [RESP_W-1:0]     left_r,    left_nxt;
  logic [7:0]            rx_r,      rx_nxt;
  logic                  trail_r,   trail_nxt;

  // output register
  logic                  ovalid_r;
  logic                  line_r,    line_nxt;
  logic                  drv_r,     drv_nxt;
  logic                  bvalid_r,  bvalid_nxt;
  logic [7:0]            rbyte_r,   rbyte_nxt;
  logic                  last_r,    last_nxt;
  logic [1:0]            status_r,  status_nxt;

  logic                  accept;

  // helpers
  logic [HEAD_BITS-1:0]  head;
  logic [RESP_W-1:0]     resp_sat;
  logic [15:0]           limit;
  logic [16:0]           wait_inc;
  logic [5:0]            bits_inc;
  logic [RESP_W-1:0]     left_dec;

  assign in_tready = !ovalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // frame head, saturated length, timeout limit
  assign head     = {FRAME_PREFIX, in_index, in_arg};
  assign resp_sat = (32'(in_resp) > 32'(MAX_RESPONSE_BYTES)) ? RESP_W'(MAX_RESPONSE_BYTES)
                                                             : RESP_W'(in_resp);
  assign limit    = (timeout_r == '0) ? 16'd1 : timeout_r;
  assign wait_inc = {1'b0, wait_r} + 17'd1;
  assign bits_inc = bits_r + 6'd1;
  assign left_dec = (left_r != '0) ? (left_r - RESP_W'(1)) : left_r;

  // next state and result for the item on the input
  always_comb begin
    phase_nxt  = phase_r;
    frame_nxt  = frame_r;
    bits_nxt   = bits_r;
    wait_nxt   = wait_r;
    left_nxt   = left_r;
    rx_nxt     = rx_r;
    trail_nxt  = trail_r;
    line_nxt   = 1'b1;
    drv_nxt    = 1'b0;
    bvalid_nxt = 1'b0;
    rbyte_nxt  = '0;
    last_nxt   = 1'b0;

    if (in_tuser == CMD_START) begin
      if (phase_r inside {PH_IDLE, PH_OK, PH_TIMEOUT}) begin
        frame_nxt = {head, crc7_of(head), 1'b1};
        left_nxt  = resp_sat;
        trail_nxt = in_trailer;
        bits_nxt  = '0;
        wait_nxt  = '0;
        rx_nxt    = '0;
        phase_nxt = PH_SEND;
      end
    end else begin
      case (phase_r)
        PH_SEND: begin
          drv_nxt   = 1'b1;
          line_nxt  = frame_r[47];
          frame_nxt = {frame_r[46:0], 1'b1};
          bits_nxt  = bits_inc;
          if (bits_inc >= FRAME_LEN) begin
            bits_nxt = '0;
            wait_nxt = '0;
            if (left_r == '0) begin
              phase_nxt = trail_r ? PH_TRAIL : PH_OK;
            end else begin
              phase_nxt = PH_WAIT;
            end
          end
        end
        PH_WAIT: begin
          if (!in_sample) begin
            rx_nxt    = '0;
            bits_nxt  = 6'd1;
            phase_nxt = PH_RECV;
          end else begin
            wait_nxt = wait_inc[15:0];
            if (wait_inc >= {1'b0, limit}) phase_nxt = PH_TIMEOUT;
          end
        end
        PH_RECV: begin
          rx_nxt   = {rx_r[6:0], in_sample};
          bits_nxt = bits_inc;
          if (bits_inc >= BYTE_LEN) begin
            bits_nxt   = '0;
            bvalid_nxt = 1'b1;
            rbyte_nxt  = {rx_r[6:0], in_sample};
            left_nxt   = left_dec;
            if (left_dec == '0) begin
              last_nxt  = 1'b1;
              phase_nxt = trail_r ? PH_TRAIL : PH_OK;
            end
          end
        end
        PH_TRAIL: begin
          drv_nxt  = 1'b1;
          bits_nxt = bits_inc;
          if (bits_inc >= BYTE_LEN) begin
            bits_nxt  = '0;
            phase_nxt = PH_OK;
          end
        end
        default: begin
        end
      endcase
    end

    // status reflects the phase after this item
    case (phase_nxt)
      PH_IDLE:    status_nxt = STAT_IDLE;
      PH_OK:      status_nxt = STAT_OK;
      PH_TIMEOUT: status_nxt = STAT_TIMEOUT;
      default:    status_nxt = STAT_BUSY;
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  // engine state, advanced once per accepted transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      frame_r <= '1;
      bits_r  <= '0;
      wait_r  <= '0;
      left_r  <= '0;
      rx_r    <= '0;
      trail_r <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      frame_r <= frame_nxt;
      bits_r  <= bits_nxt;
      wait_r  <= wait_nxt;
      left_r  <= left_nxt;
      rx_r    <= rx_nxt;
      trail_r <= trail_nxt;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (accept) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      line_r   <= line_nxt;
      drv_r    <= drv_nxt;
      bvalid_r <= bvalid_nxt;
      rbyte_r  <= rbyte_nxt;
      last_r   <= last_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {4'b0000, status_r, rbyte_r, drv_r, line_r};
  assign out_tuser  = bvalid_r;
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

// File: rtl/core/sdcle_checker.sv
// ----------------------------------------------------------------------------
// SD command line engine - port checker
// Watches the core's ports over time and flags inconsistent results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sd_command_line_engine_core_macros.svh"

module sdcle_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [sdcle_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire logic                              out_tuser,
  input wire logic                              out_tlast
);

  import sdcle_pkg::*;

  // a stalled result holds
  `SDCLE_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")

  // an accepted transfer always yields a result in the next cycle
  `SDCLE_ASSERT_NXT(a_result_follows, clk, rst_n, in_tvalid && in_tready, out_tvalid, "accepted transfer gave no result")

  // last byte only with a valid byte, no byte field otherwise
  `SDCLE_ASSERT_IMP(a_last_needs_byte, clk, rst_n, out_tvalid && !out_tuser, !out_tlast && (out_tdata[9:2] == 8'h00), "byte fields set without byte valid")

  // a captured byte is never reported while the host drives the line, nor with idle or timeout status
  `SDCLE_ASSERT_IMP(a_byte_not_driving, clk, rst_n, out_tvalid && out_tuser, !out_tdata[1] && (out_tdata[11:10] != STAT_IDLE) && (out_tdata[11:10] != STAT_TIMEOUT), "byte reported in wrong line mode")

  // a released line reads as 1
  `SDCLE_ASSERT_IMP(a_released_high, clk, rst_n, out_tvalid && !out_tdata[1], out_tdata[0], "released line not high")

endmodule

bind sd_command_line_engine_core sdcle_checker u_sdcle_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
